>>> rtl/core/sem_pkg.sv
// Shared types, constants and arithmetic helpers of the RGB Sobel edge magnitude block.
// Used by sem_ctrl, sem_datapath and sobel_edge_magnitude_rgb_top; no dependencies.
package sem_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int CFG_W      = 12;
    localparam int ROW_W      = 13;
    localparam int COUNT_W    = 23;
    localparam int PIX_W      = 24;
    localparam int CH_W       = 8;
    localparam int SUMSQ_W    = 21;
    localparam int ROOT_W     = 16;
    localparam int SQRT_STEPS = 8;
    localparam int CNT_W      = 5;

    localparam logic [ROW_W-1:0] ROW_LIMIT    = {ROW_W{1'b1}};
    localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;
    localparam logic [COUNT_W-1:0] TOTAL_RESET =
        {{(COUNT_W-CFG_W){1'b0}}, WIDTH_RESET} * {{(COUNT_W-CFG_W){1'b0}}, HEIGHT_RESET};
    localparam logic [CH_W-1:0]  EDGE_MAX     = 8'd255;

    // Configuration register indexes.
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic       accept;
        logic       win;
        logic       grad;
        logic       sqrt_step;
        logic [2:0] sq_idx;
        logic       out_load;
        logic       update;
        logic       total_load;
        logic       div_init;
        logic       div_step;
    } sem_cmd_t;

    typedef struct packed {
        logic emit;
        logic out_free;
    } sem_status_t;

    // Sum of squares of the Sobel gradients for one channel; the center tap has
    // weight zero in both kernels and is left out.
    function automatic logic [SUMSQ_W-1:0] sem_sumsq(
        input logic [CH_W-1:0] tl, input logic [CH_W-1:0] tm, input logic [CH_W-1:0] tr,
        input logic [CH_W-1:0] ml, input logic [CH_W-1:0] mr,
        input logic [CH_W-1:0] bl, input logic [CH_W-1:0] bm, input logic [CH_W-1:0] br);
        logic signed [11:0] gx;
        logic signed [11:0] gy;
        logic [9:0]  ax;
        logic [9:0]  ay;
        logic [19:0] sx;
        logic [19:0] sy;
        gx = $signed({4'd0, tr}) + $signed({3'd0, mr, 1'b0}) + $signed({4'd0, br})
           - $signed({4'd0, tl}) - $signed({3'd0, ml, 1'b0}) - $signed({4'd0, bl});
        gy = $signed({4'd0, bl}) + $signed({3'd0, bm, 1'b0}) + $signed({4'd0, br})
           - $signed({4'd0, tl}) - $signed({3'd0, tm, 1'b0}) - $signed({4'd0, tr});
        ax = gx[11] ? 10'(-gx) : gx[9:0];
        ay = gy[11] ? 10'(-gy) : gy[9:0];
        sx = ax * ax;
        sy = ay * ay;
        return {1'b0, sx} + {1'b0, sy};
    endfunction

endpackage

>>> rtl/core/sem_ctrl.sv
// Sequencing state machine of the Sobel edge magnitude block.
// Depends on sem_pkg; drives sem_datapath through sem_cmd_t.
module sem_ctrl
    import sem_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        cfg_we,
    input  sem_status_t status,
    output sem_cmd_t    cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_WIN   = 4'd1;
    localparam logic [3:0] ST_GRAD  = 4'd2;
    localparam logic [3:0] ST_SQRT  = 4'd3;
    localparam logic [3:0] ST_OUT   = 4'd4;
    localparam logic [3:0] ST_UPD   = 4'd5;
    localparam logic [3:0] ST_TOTAL = 4'd6;
    localparam logic [3:0] ST_DINIT = 4'd7;
    localparam logic [3:0] ST_DIV   = 4'd8;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign s_tready = (state_reg == ST_IDLE) && !cfg_we;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.sq_idx = cnt_reg[2:0];
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    cmd.accept = 1'b1;
                    state_next = ST_WIN;
                end
            end
            ST_WIN: begin
                cmd.win    = 1'b1;
                state_next = status.emit ? ST_GRAD : ST_UPD;
            end
            ST_GRAD: begin
                cmd.grad   = 1'b1;
                cnt_next   = '0;
                state_next = ST_SQRT;
            end
            ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SQRT_STEPS - 1)) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_UPD;
                end
            end
            ST_UPD: begin
                cmd.update = 1'b1;
                state_next = ST_IDLE;
            end
            ST_TOTAL: begin
                cmd.total_load = 1'b1;
                state_next     = ST_DINIT;
            end
            ST_DINIT: begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(COUNT_W - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        // A register write restarts the frame-size bookkeeping.
        if (cfg_we) begin
            state_next = ST_TOTAL;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

>>> rtl/core/sem_datapath.sv
// Datapath of the Sobel edge magnitude block: line store, window, counters,
// gradient, square root, divider and output register. Depends on sem_pkg.
module sem_datapath
    import sem_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  sem_cmd_t             cmd,
    output sem_status_t          status,
    input  logic                 cfg_we,
    input  logic                 cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic [PIX_W-1:0]     s_tdata,
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [PIX_W-1:0]     m_tdata,
    output logic                 m_tlast,
    output logic                 m_tuser
);

    logic [CFG_W-1:0]   width_reg, height_reg;
    logic [CFG_W-1:0]   weff, heff;
    logic [COUNT_W-1:0] total_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COL_W-1:0]   in_col_reg;
    logic [ROW_W-1:0]   in_row_reg;
    logic [COL_W-1:0]   ocol_reg;
    logic [COUNT_W-1:0] orow_reg;
    logic [COL_W-1:0]   col_reg;
    logic [PIX_W-1:0]   pix_reg;
    logic               emit_reg;
    logic [COL_W-1:0]   col;
    logic [2*PIX_W-1:0] mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] rd_reg;
    logic [PIX_W-1:0]   win_reg [3][3];
    logic [ROOT_W-1:0]  v_reg [3];
    logic [ROOT_W-1:0]  res_reg [3];
    logic               sat_reg [3];
    logic [SUMSQ_W-1:0] sumsq [3];
    logic [CH_W-1:0]    px [3][3][3];
    logic               cval [3];
    logic               rval [3];
    logic [ROOT_W-1:0]  sq_bit;
    logic [ROOT_W:0]    trial [3];
    logic               m_tvalid_reg;
    logic [PIX_W-1:0]   m_tdata_reg;
    logic               m_tlast_reg, m_tuser_reg;
    logic [COUNT_W-1:0] count_n;
    logic [CFG_W:0]     div_sh;
    logic               div_ge;

    assign weff = (width_reg == '0) ? CFG_W'(1) :
                  (width_reg > CFG_W'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : width_reg;
    assign heff = (height_reg == '0) ? CFG_W'(1) : height_reg;

    assign col = ({1'b0, in_col_reg} < weff) ? in_col_reg : '0;

    assign status.emit     = emit_reg;
    assign status.out_free = !m_tvalid_reg || m_tready;

    // Line store: older row in the low half, newer row in the high half.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            rd_reg <= mem[col];
        end
        if (cmd.win) begin
            mem[col_reg] <= {pix_reg, rd_reg[2*PIX_W-1:PIX_W]};
        end
    end

    // Border masks and masked window bytes for each channel.
    always_comb begin
        cval[0] = ocol_reg != '0;
        cval[1] = 1'b1;
        cval[2] = ({1'b0, ocol_reg} + 1'b1) < weff;
        rval[0] = orow_reg != '0;
        rval[1] = 1'b1;
        rval[2] = ({1'b0, orow_reg} + 1'b1) < {12'd0, heff};
        for (int ch = 0; ch < 3; ch++) begin
            for (int a = 0; a < 3; a++) begin
                for (int b = 0; b < 3; b++) begin
                    px[ch][a][b] = (cval[a] && rval[b]) ? win_reg[a][b][CH_W*ch +: CH_W] : '0;
                end
            end
            sumsq[ch] = sem_sumsq(px[ch][0][0], px[ch][1][0], px[ch][2][0],
                                  px[ch][0][1], px[ch][2][1],
                                  px[ch][0][2], px[ch][1][2], px[ch][2][2]);
        end
    end

    always_comb begin
        sq_bit = 16'h4000 >> {cmd.sq_idx, 1'b0};
        for (int ch = 0; ch < 3; ch++) begin
            trial[ch] = {1'b0, res_reg[ch]} + {1'b0, sq_bit};
        end
    end

    always_ff @(posedge aclk) begin
        for (int ch = 0; ch < 3; ch++) begin
            if (cmd.grad) begin
                v_reg[ch]   <= sumsq[ch][ROOT_W-1:0];
                sat_reg[ch] <= |sumsq[ch][SUMSQ_W-1:ROOT_W];
                res_reg[ch] <= '0;
            end else if (cmd.sqrt_step) begin
                if ({1'b0, v_reg[ch]} >= trial[ch]) begin
                    v_reg[ch]   <= v_reg[ch] - trial[ch][ROOT_W-1:0];
                    res_reg[ch] <= (res_reg[ch] >> 1) + sq_bit;
                end else begin
                    res_reg[ch] <= res_reg[ch] >> 1;
                end
            end
        end
    end

    // Item capture and window shift.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            pix_reg <= s_tuser ? '0 : s_tdata;
            col_reg <= col;
        end
        if (!aresetn) begin
            emit_reg <= 1'b0;
            for (int a = 0; a < 3; a++) begin
                for (int b = 0; b < 3; b++) begin
                    win_reg[a][b] <= '0;
                end
            end
        end else begin
            if (cmd.accept) begin
                emit_reg <= (in_row_reg >= ROW_W'(2)) ||
                            (in_row_reg == ROW_W'(1) && col != '0);
            end
            if (cmd.win) begin
                for (int b = 0; b < 3; b++) begin
                    win_reg[0][b] <= win_reg[1][b];
                    win_reg[1][b] <= win_reg[2][b];
                end
                win_reg[2][0] <= rd_reg[PIX_W-1:0];
                win_reg[2][1] <= rd_reg[2*PIX_W-1:PIX_W];
                win_reg[2][2] <= pix_reg;
            end
        end
    end

    assign count_n = count_reg + COUNT_W'(emit_reg);
    assign div_sh  = {1'b0, ocol_reg, orow_reg[COUNT_W-1]};
    assign div_ge  = div_sh >= {1'b0, weff};

    // Configuration, frame size and position counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            total_reg  <= TOTAL_RESET;
            count_reg  <= '0;
            in_col_reg <= '0;
            in_row_reg <= '0;
            ocol_reg   <= '0;
            orow_reg   <= '0;
        end else begin
            if (cfg_we) begin
                if (cfg_addr == REG_FRAME_WIDTH) begin
                    width_reg <= cfg_wdata;
                end else begin
                    height_reg <= cfg_wdata;
                end
            end
            if (cmd.total_load) begin
                total_reg <= {{(COUNT_W-CFG_W){1'b0}}, weff} *
                             {{(COUNT_W-CFG_W){1'b0}}, heff};
            end
            if (cmd.div_init) begin
                ocol_reg <= '0;
                if (count_reg >= total_reg) begin
                    count_reg  <= '0;
                    in_col_reg <= '0;
                    in_row_reg <= '0;
                    orow_reg   <= '0;
                end else begin
                    orow_reg <= count_reg;
                end
            end
            // Restoring division of the result count by the width.
            if (cmd.div_step) begin
                ocol_reg <= div_ge ? COL_W'(div_sh - {1'b0, weff}) : COL_W'(div_sh);
                orow_reg <= {orow_reg[COUNT_W-2:0], div_ge};
            end
            if (cmd.update) begin
                if (count_n >= total_reg) begin
                    count_reg  <= '0;
                    in_col_reg <= '0;
                    in_row_reg <= '0;
                    ocol_reg   <= '0;
                    orow_reg   <= '0;
                end else begin
                    count_reg <= count_n;
                    if (emit_reg) begin
                        if (({1'b0, ocol_reg} + 1'b1) == weff) begin
                            ocol_reg <= '0;
                            orow_reg <= orow_reg + 1'b1;
                        end else begin
                            ocol_reg <= ocol_reg + 1'b1;
                        end
                    end
                    if (({1'b0, col_reg} + 1'b1) >= weff) begin
                        in_col_reg <= '0;
                        if (in_row_reg < ROW_LIMIT) begin
                            in_row_reg <= in_row_reg + 1'b1;
                        end
                    end else begin
                        in_col_reg <= col_reg + 1'b1;
                    end
                end
            end
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            for (int ch = 0; ch < 3; ch++) begin
                m_tdata_reg[CH_W*ch +: CH_W] <= sat_reg[ch] ? EDGE_MAX : res_reg[ch][CH_W-1:0];
            end
            m_tlast_reg <= ({1'b0, ocol_reg} + 1'b1) == weff;
            m_tuser_reg <= (count_reg + 1'b1) == total_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

>>> rtl/core/sobel_edge_magnitude_rgb_top.sv
// Top level of the RGB Sobel edge magnitude block: sem_ctrl plus sem_datapath.
// An item that yields no result passes capture, window update and counter update; one that
// yields a result also passes the gradient, the 8-step square-root units of the three
// channels and the output load, which waits while the output register is still full.
// A configuration write starts frame-size bookkeeping (product plus a 23-step division)
// during which no input is taken. aresetn is synchronous, active low, and restores
// 640 x 480, clears counters and window; the line store is not cleared.
module sobel_edge_magnitude_rgb_top
    import sem_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    // Input pixel transfers.
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [PIX_W-1:0] s_tdata,   // pixel_red, pixel_green, pixel_blue
    input  logic             s_tuser,   // flush
    // Result transfers.
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [PIX_W-1:0] m_tdata,   // edge_red, edge_green, edge_blue
    output logic             m_tlast,   // end_of_row
    output logic             m_tuser,   // end_of_frame
    // Register writes: index 0 is frame_width, index 1 is frame_height.
    input  logic             cfg_we,
    input  logic             cfg_addr,
    input  logic [CFG_W-1:0] cfg_wdata
);

    sem_cmd_t    cmd;
    sem_status_t status;

    // The controller walks each item through capture, window update and, for an item that
    // yields a result, gradient, root extraction and output; the datapath holds all storage.
    sem_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cfg_we   (cfg_we),
        .status   (status),
        .cmd      (cmd)
    );

    sem_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for sobel_edge_magnitude_rgb_top: frames of random RGB pixels
// are streamed in and every result is compared with a built-in edge predictor.
// Depends on sem_pkg and the block's RTL only.
module tb;
    import sem_pkg::*;

    // Clock, reset and the block's ports.
    logic             aclk;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [PIX_W-1:0] s_tdata;    // pixel_red, pixel_green, pixel_blue
    logic             s_tuser;    // flush
    logic             m_tvalid;
    logic             m_tready;
    logic [PIX_W-1:0] m_tdata;    // edge_red, edge_green, edge_blue
    logic             m_tlast;    // end_of_row
    logic             m_tuser;    // end_of_frame
    logic             cfg_we;
    logic             cfg_addr;
    logic [CFG_W-1:0] cfg_wdata;

    sobel_edge_magnitude_rgb_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // One edge result as it leaves the block.
    typedef struct {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        bit              row_end;
        bit              frame_end;
    } edge_t;

    // One row of the directed table. A known magnitude of -1 means the result, if any,
    // comes from the predictor alone; otherwise all three channels must equal it.
    typedef struct {
        logic [PIX_W-1:0] pixel;
        bit               flush;
        int               known_mag;
    } pixel_row_t;

    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int SETTLE_WAIT  = 40;  // longer than any pending item or register update
    localparam int RANDOM_ITEMS = 620;

    edge_t expected_edges[$];
    int    fail_count;
    int    cycle_count;
    int    items_sent;

    // Idle percentages of the sender and the receiver, changed as the run goes on.
    int    send_idle_pct;
    int    recv_idle_pct;

    // Shadow of the block: registers, line stores, window and position counters.
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [PIX_W-1:0] older_row[MAX_WIDTH];
    logic [PIX_W-1:0] newer_row[MAX_WIDTH];
    logic [PIX_W-1:0] window[3][3];   // [column: left, mid, right][row: top, mid, bottom]
    int unsigned      in_col;
    int unsigned      in_row;
    int unsigned      out_count;

    function automatic int unsigned active_width();
        if (width_reg == 0) return 1;
        if (width_reg > MAX_WIDTH) return MAX_WIDTH;
        return int'(width_reg);
    endfunction

    function automatic int unsigned active_height();
        return (height_reg == 0) ? 1 : int'(height_reg);
    endfunction

    // Floor of the root of the sum of squares, saturated at the channel maximum.
    function automatic logic [CH_W-1:0] grad_magnitude(int gx, int gy);
        int unsigned sum;
        int unsigned root;
        sum  = gx * gx + gy * gy;
        root = 0;
        if (sum >= 65536) return EDGE_MAX;
        while ((root + 1) * (root + 1) <= sum) root++;
        return root[CH_W-1:0];
    endfunction

    // Advances the shadow by one accepted item and reports the result it causes.
    task automatic sobel_predict(input logic [PIX_W-1:0] pixel, input bit flush,
                                 output bit produced, output edge_t res);
        int unsigned w;
        int unsigned h;
        int unsigned total;
        int unsigned col;
        int unsigned orow;
        int unsigned ocol;
        logic [PIX_W-1:0] pix;
        bit col_ok[3];
        bit row_ok[3];
        logic [CH_W-1:0] mag[3];
        int gx;
        int gy;
        int v;
        w        = active_width();
        h        = active_height();
        total    = w * h;
        produced = 0;
        res      = '{default: 0};
        if (out_count >= total) begin
            in_col = 0; in_row = 0; out_count = 0;
        end
        pix = flush ? '0 : pixel;
        col = (in_col < w) ? in_col : 0;
        for (int a = 0; a < 2; a++)
            for (int b = 0; b < 3; b++)
                window[a][b] = window[a+1][b];
        window[2][0]   = older_row[col];
        window[2][1]   = newer_row[col];
        window[2][2]   = pix;
        older_row[col] = newer_row[col];
        newer_row[col] = pix;

        if (in_row >= 2 || (in_row == 1 && col >= 1)) begin
            orow = out_count / w;
            ocol = out_count % w;
            col_ok = '{ocol > 0, 1'b1, ocol + 1 < w};
            row_ok = '{orow > 0, 1'b1, orow + 1 < h};
            for (int ch = 0; ch < 3; ch++) begin
                gx = 0;
                gy = 0;
                for (int a = 0; a < 3; a++)
                    for (int b = 0; b < 3; b++)
                        if (col_ok[a] && row_ok[b]) begin
                            v  = int'(window[a][b][8*ch +: 8]);
                            // Center row and column carry weight two in the kernels.
                            gx += v * (a - 1) * ((b == 1) ? 2 : 1);
                            gy += v * (b - 1) * ((a == 1) ? 2 : 1);
                        end
                mag[ch] = grad_magnitude(gx, gy);
            end
            res.red       = mag[0];
            res.green     = mag[1];
            res.blue      = mag[2];
            res.row_end   = (ocol + 1 == w);
            res.frame_end = (out_count + 1 == total);
            out_count++;
            produced = 1;
        end

        if (out_count >= total) begin
            in_col = 0; in_row = 0; out_count = 0;
        end else if (col + 1 >= w) begin
            in_col = 0;
            if (in_row < ROW_LIMIT) in_row++;
        end else begin
            in_col = col + 1;
        end
    endtask

    // Free-running clock.
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Timeout guard.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // The receiver stalls at random; the ready line moves on the falling edge only.
    always @(negedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else          m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Result checker: every result transfer is matched against the oldest expectation.
    always @(posedge aclk) begin
        edge_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_edges.size() == 0) begin
                $error("unexpected result transfer: data %h last %b user %b",
                       m_tdata, m_tlast, m_tuser);
                fail_count++;
            end else begin
                want = expected_edges.pop_front();
                if (m_tdata[7:0] !== want.red) begin
                    $error("edge_red: expected %0d, got %0d", want.red, m_tdata[7:0]);
                    fail_count++;
                end
                if (m_tdata[15:8] !== want.green) begin
                    $error("edge_green: expected %0d, got %0d", want.green, m_tdata[15:8]);
                    fail_count++;
                end
                if (m_tdata[23:16] !== want.blue) begin
                    $error("edge_blue: expected %0d, got %0d", want.blue, m_tdata[23:16]);
                    fail_count++;
                end
                if (m_tlast !== want.row_end) begin
                    $error("end_of_row: expected %0d, got %0d", want.row_end, m_tlast);
                    fail_count++;
                end
                if (m_tuser !== want.frame_end) begin
                    $error("end_of_frame: expected %0d, got %0d", want.frame_end, m_tuser);
                    fail_count++;
                end
            end
        end
    end

    // The idling pattern follows the number of items sent so far: first a lazy receiver,
    // then a lazy sender, then a stream with no gaps at all.
    function automatic void update_idling();
        if (items_sent < 250) begin
            send_idle_pct = 18; recv_idle_pct = 59;
        end else if (items_sent < 500) begin
            send_idle_pct = 59; recv_idle_pct = 18;
        end else begin
            send_idle_pct = 0;  recv_idle_pct = 0;
        end
    endfunction

    // Sends one item, starting and ending at a falling edge. Returns after the transfer.
    task automatic push_pixel(input logic [PIX_W-1:0] pixel, input bit flush,
                              input int known_mag);
        bit    produced;
        edge_t res;
        update_idling();
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pixel;
        s_tuser  <= flush;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sobel_predict(pixel, flush, produced, res);
        if (produced) begin
            if (known_mag >= 0) begin
                res.red   = known_mag[7:0];
                res.green = known_mag[7:0];
                res.blue  = known_mag[7:0];
            end
            expected_edges.push_back(res);
        end
        items_sent++;
        @(negedge aclk);
    endtask

    // Waits until all results are back and the block has had time to settle.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_edges.size() != 0) @(posedge aclk);
        repeat (SETTLE_WAIT) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Register write; the caller is to issue it only while the block is idle, the task itself does not wait for that.
    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        if (idx == REG_FRAME_WIDTH) width_reg  = value;
        else                        height_reg = value;
    endtask

    function automatic logic [CH_W-1:0] pick_channel(int style, logic [CH_W-1:0] base);
        case (style)
            0:       return CH_W'($urandom_range(0, 255));
            1:       return base + CH_W'($urandom_range(0, 12));   // gentle slopes
            default: return $urandom_range(0, 1) ? EDGE_MAX : 8'd0;
        endcase
    endfunction

    // One whole frame of random content followed by the flush items that drain it.
    // Returns the number of items it sent.
    task automatic run_frame(input logic [CFG_W-1:0] w_val, input logic [CFG_W-1:0] h_val,
                             output int count);
        int unsigned pixels;
        int unsigned w;
        int style;
        logic [CH_W-1:0] base;
        logic [PIX_W-1:0] pix;
        wait_drained();
        write_reg(REG_FRAME_WIDTH, w_val);
        write_reg(REG_FRAME_HEIGHT, h_val);
        w      = active_width();
        pixels = w * active_height();
        style  = $urandom_range(0, 2);
        base   = CH_W'($urandom_range(0, 240));
        for (int unsigned i = 0; i < pixels; i++) begin
            pix = {pick_channel(style, base), pick_channel(style, base),
                   pick_channel(style, base)};
            // Now and then a flush inside the frame stands in for a zero pixel.
            push_pixel(pix, $urandom_range(0, 99) < 6, -1);
        end
        // The data of a flush item is ignored, so it carries noise.
        for (int unsigned i = 0; i <= w; i++)
            push_pixel(PIX_W'($urandom), 1'b1, -1);
        count = pixels + w + 1;
    endtask

    pixel_row_t directed[$];

    initial begin
        int n;
        int random_items;
        fail_count    = 0;
        cycle_count   = 0;
        items_sent    = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = REG_FRAME_WIDTH;
        cfg_wdata     = '0;
        width_reg     = WIDTH_RESET;
        height_reg    = HEIGHT_RESET;
        in_col        = 0;
        in_row        = 0;
        out_count     = 0;
        for (int a = 0; a < 3; a++)
            for (int b = 0; b < 3; b++)
                window[a][b] = '0;
        for (int i = 0; i < MAX_WIDTH; i++) begin
            older_row[i] = '0;
            newer_row[i] = '0;
        end

        // First a flat white 3x3 frame: every result lies on the border and saturates,
        // except the center, where both gradients cancel to zero. The first four items
        // cause no result. Then a frame of extremes and mid-range values with a flush in the
        // middle, checked by the predictor.
        for (int i = 0; i < 13; i++)
            directed.push_back('{24'hFFFFFF, (i >= 9), (i == 8) ? 0 : 255});
        directed.push_back('{24'h000000, 1'b0, -1});
        directed.push_back('{24'hFFFFFF, 1'b0, -1});
        directed.push_back('{24'h0000FF, 1'b0, -1});
        directed.push_back('{24'h00FF00, 1'b0, -1});
        directed.push_back('{24'hFFFFFF, 1'b1, -1});
        directed.push_back('{24'hFF0000, 1'b0, -1});
        directed.push_back('{24'h010101, 1'b0, -1});
        directed.push_back('{24'h808080, 1'b0, -1});
        directed.push_back('{24'hFE7F01, 1'b0, -1});
        for (int i = 0; i < 4; i++)
            directed.push_back('{24'h5AA55A, 1'b1, -1});

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        write_reg(REG_FRAME_WIDTH, 12'd3);
        write_reg(REG_FRAME_HEIGHT, 12'd3);
        foreach (directed[i])
            push_pixel(directed[i].pixel, directed[i].flush, directed[i].known_mag);

        // Registers of zero stand for a 1x1 frame; then single rows and columns.
        run_frame(12'd0, 12'd0, n);
        run_frame(12'd1, 12'd1, n);
        run_frame(12'd1, 12'd6, n);
        run_frame(12'd7, 12'd1, n);

        // Random small frames make up the bulk of the run.
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            run_frame(CFG_W'($urandom_range(1, 12)), CFG_W'($urandom_range(1, 9)), n);
            random_items += n;
        end

        // A last small frame after the gap-free stretch.
        run_frame(12'd4, 12'd3, n);

        wait_drained();
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
